>>> sv/tasd_pkg.sv
package tasd_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_STEPS_DEFAULT   = 8;
    localparam int NUM_ACTIONS_DEFAULT = 16;
    localparam int TIME_BITS_DEFAULT   = 16;

    // Fixed layout of the configuration registers.
    localparam int SLOT_COUNT = 8;
    localparam int STEP_BITS  = 3;
    localparam int ID_BITS    = 4;
    localparam int MASK_BITS  = 16;
    localparam int FIELD_BITS = 16;
    localparam int COUNT_BITS = 4;
    localparam int CFG_BITS   = 64;
    localparam int INDEX_BITS = 3;

    // Configuration register indexes.
    localparam logic [INDEX_BITS-1:0] REG_STEP_COUNT    = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_STEP_ACTIONS  = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_TIMEOUTS_LOW  = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_TIMEOUTS_HIGH = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_CANCEL_MASK   = 3'd4;

    typedef enum logic [1:0] {
        TRIG_NONE      = 2'd0,
        TRIG_ONGOING   = 2'd1,
        TRIG_TRIGGERED = 2'd2
    } trig_state_t;

    typedef enum logic [2:0] {
        EV_IDLE         = 3'd0,
        EV_CANCELLED    = 3'd1,
        EV_OUT_OF_ORDER = 3'd2,
        EV_TIMEOUT      = 3'd3,
        EV_ADVANCED     = 3'd4,
        EV_COMPLETED    = 3'd5
    } event_t;

    // One result word as it leaves the evaluation logic.
    typedef struct packed {
        trig_state_t           trigger_state;
        event_t                event_code;
        logic [STEP_BITS-1:0]  step_index;
    } result_t;

endpackage

>>> sv/tasd_eval.sv
module tasd_eval
    import tasd_pkg::*;
#(
    parameter int MAX_STEPS   = MAX_STEPS_DEFAULT,
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEFAULT,
    parameter int TIME_BITS   = TIME_BITS_DEFAULT
)
(
    input  logic [COUNT_BITS-1:0]          step_count,
    input  logic [SLOT_COUNT*ID_BITS-1:0]  step_actions,
    input  logic [CFG_BITS-1:0]            step_timeouts_low,
    input  logic [CFG_BITS-1:0]            step_timeouts_high,
    input  logic [MASK_BITS-1:0]           cancel_mask,
    input  logic [STEP_BITS-1:0]           step_cur,
    input  logic [TIME_BITS-1:0]           time_cur,
    input  logic                           started_cur,
    input  logic [MASK_BITS-1:0]           fired_mask,
    input  logic [FIELD_BITS-1:0]          elapsed_ticks,
    output logic [STEP_BITS-1:0]           step_new,
    output logic [TIME_BITS-1:0]           time_new,
    output logic                           started_new,
    output result_t                        result
);

    // Compare width wide enough for both the elapsed field and the countdown.
    localparam int CW  = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
    localparam int CAP = (MAX_STEPS < SLOT_COUNT) ? MAX_STEPS : SLOT_COUNT;
    localparam logic [CW-1:0] TIME_MAX = CW'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [MASK_BITS-1:0] VALID_BITS = (NUM_ACTIONS >= MASK_BITS) ?
        {MASK_BITS{1'b1}} : MASK_BITS'((64'd1 << NUM_ACTIONS) - 64'd1);

    // One-hot bit of the action id of step k, limited to real action ids.
    function automatic logic [MASK_BITS-1:0] action_bit(input logic [STEP_BITS-1:0] k);
        logic [ID_BITS-1:0]   id;
        logic [MASK_BITS-1:0] b;
        id = step_actions[{k, 2'b00} +: ID_BITS];
        b  = MASK_BITS'(1) << id;
        return b & VALID_BITS;
    endfunction

    // Timeout of step k, saturated to the countdown width.
    function automatic logic [TIME_BITS-1:0] step_timeout(input logic [STEP_BITS-1:0] k);
        logic [CFG_BITS-1:0] word;
        logic [CW-1:0]       t;
        word = k[2] ? step_timeouts_high : step_timeouts_low;
        t    = CW'(word[{k[1:0], 4'b0000} +: FIELD_BITS]);
        return (t > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : t[TIME_BITS-1:0];
    endfunction

    logic [COUNT_BITS-1:0] count;
    logic [MASK_BITS-1:0]  fired;
    logic                  restart0;
    logic [STEP_BITS-1:0]  step0;
    logic [TIME_BITS-1:0]  time0;
    logic [MASK_BITS-1:0]  cur_bit;
    logic [MASK_BITS-1:0]  step_bits;
    logic [COUNT_BITS-1:0] step_plus;

    // Effective step count, the first-tick mask drop and the restart rule.
    always_comb
    begin
        count     = (step_count > COUNT_BITS'(CAP)) ? COUNT_BITS'(CAP) : step_count;
        fired     = started_cur ? (fired_mask & VALID_BITS) : '0;
        restart0  = !started_cur || ({1'b0, step_cur} >= count);
        step0     = restart0 ? '0 : step_cur;
        time0     = restart0 ? step_timeout('0) : time_cur;
        cur_bit   = action_bit(step0);
        step_plus = {1'b0, step0} + COUNT_BITS'(1);
        step_bits = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (COUNT_BITS'(k) < count)
                step_bits = step_bits | action_bit(STEP_BITS'(k));
        end
    end

    // Checks in priority order: cancel, out of order, timeout, advance.
    always_comb
    begin
        step_new             = step_cur;
        time_new             = time_cur;
        started_new          = started_cur;
        result.trigger_state = TRIG_NONE;
        result.event_code    = EV_IDLE;
        if (count != '0)
        begin
            started_new          = 1'b1;
            result.trigger_state = TRIG_ONGOING;
            step_new             = step0;
            time_new             = time0;
            if ((cancel_mask & fired & ~cur_bit) != '0)
            begin
                step_new             = '0;
                time_new             = step_timeout('0);
                result.trigger_state = TRIG_NONE;
                result.event_code    = EV_CANCELLED;
            end
            else if ((step_bits & fired & ~cur_bit) != '0)
            begin
                step_new             = '0;
                time_new             = step_timeout('0);
                result.trigger_state = TRIG_NONE;
                result.event_code    = EV_OUT_OF_ORDER;
            end
            else if ((step0 != '0) && (CW'(elapsed_ticks) >= CW'(time0)))
            begin
                step_new             = '0;
                time_new             = step_timeout('0);
                result.trigger_state = TRIG_NONE;
                result.event_code    = EV_TIMEOUT;
            end
            else
            begin
                // The countdown only runs past the first step.
                if (step0 != '0)
                    time_new = time0 - TIME_BITS'(elapsed_ticks);
                if ((fired & cur_bit) != '0)
                begin
                    if (step_plus >= count)
                    begin
                        step_new             = '0;
                        time_new             = step_timeout('0);
                        result.trigger_state = TRIG_TRIGGERED;
                        result.event_code    = EV_COMPLETED;
                    end
                    else
                    begin
                        step_new          = step_plus[STEP_BITS-1:0];
                        time_new          = step_timeout(step_plus[STEP_BITS-1:0]);
                        result.event_code = EV_ADVANCED;
                    end
                end
            end
        end
        result.step_index = step_new;
    end

endmodule

>>> sv/timed_action_sequence_detector.sv
// An accepted tick word's result word is registered and shows in the cycle after acceptance.
// Throughput: one tick per cycle while out_ready holds; the output register frees
// when its word is taken, and the sequence state updates on the accepting edge.
// Reset clears the configuration registers, the step, the countdown, the started flag
// and the output valid; the first tick after reset drops its fired mask.
module timed_action_sequence_detector
    import tasd_pkg::*;
#(
    parameter int MAX_STEPS   = MAX_STEPS_DEFAULT,
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEFAULT,
    parameter int TIME_BITS   = TIME_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MASK_BITS-1:0]  fired_mask,
    input  logic [FIELD_BITS-1:0] elapsed_ticks,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            trigger_state,
    output logic [2:0]            event_code,
    output logic [STEP_BITS-1:0]  step_index
);

    logic [COUNT_BITS-1:0]         step_count_reg;
    logic [SLOT_COUNT*ID_BITS-1:0] step_actions_reg;
    logic [CFG_BITS-1:0]           timeouts_low_reg;
    logic [CFG_BITS-1:0]           timeouts_high_reg;
    logic [MASK_BITS-1:0]          cancel_mask_reg;

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    logic                 started_reg;
    logic                 started_next;
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;
    logic                 accept;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg    <= '0;
            step_actions_reg  <= '0;
            timeouts_low_reg  <= '0;
            timeouts_high_reg <= '0;
            cancel_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_COUNT:    step_count_reg    <= cfg_data[COUNT_BITS-1:0];
                REG_STEP_ACTIONS:  step_actions_reg  <= cfg_data[SLOT_COUNT*ID_BITS-1:0];
                REG_TIMEOUTS_LOW:  timeouts_low_reg  <= cfg_data;
                REG_TIMEOUTS_HIGH: timeouts_high_reg <= cfg_data;
                REG_CANCEL_MASK:   cancel_mask_reg   <= cfg_data[MASK_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // A new word enters whenever the output register is empty or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    tasd_eval #(
        .MAX_STEPS   (MAX_STEPS),
        .NUM_ACTIONS (NUM_ACTIONS),
        .TIME_BITS   (TIME_BITS)
    ) u_eval (
        .step_count         (step_count_reg),
        .step_actions       (step_actions_reg),
        .step_timeouts_low  (timeouts_low_reg),
        .step_timeouts_high (timeouts_high_reg),
        .cancel_mask        (cancel_mask_reg),
        .step_cur           (step_reg),
        .time_cur           (time_reg),
        .started_cur        (started_reg),
        .fired_mask         (fired_mask),
        .elapsed_ticks      (elapsed_ticks),
        .step_new           (step_next),
        .time_new           (time_next),
        .started_new        (started_next),
        .result             (result_next)
    );

    // Sequence state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            time_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                step_reg    <= step_next;
                time_reg    <= time_next;
                started_reg <= started_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign trigger_state = result_reg.trigger_state;
    assign event_code    = result_reg.event_code;
    assign step_index    = result_reg.step_index;

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import tasd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 90;

    typedef struct packed {
        logic [MASK_BITS-1:0]  fired;
        logic [FIELD_BITS-1:0] elapsed;
    } tick_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]   cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MASK_BITS-1:0]  fired_mask = '0;
    logic [FIELD_BITS-1:0] elapsed_ticks = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            trigger_state;
    logic [2:0]            event_code;
    logic [STEP_BITS-1:0]  step_index;

    timed_action_sequence_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .fired_mask    (fired_mask),
        .elapsed_ticks (elapsed_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .trigger_state (trigger_state),
        .event_code    (event_code),
        .step_index    (step_index)
    );

    // Shadow copy of the configuration registers.
    logic [3:0]  cfg_count = '0;
    logic [31:0] cfg_actions = '0;
    logic [63:0] cfg_timeouts_lo = '0;
    logic [63:0] cfg_timeouts_hi = '0;
    logic [15:0] cfg_cancel = '0;

    // Sequence state as the detector should hold it.
    int          seq_step = 0;
    logic [15:0] seq_remaining = '0;
    bit          seq_started = 1'b0;

    tick_t   tick_queue[$];
    result_t pending_results[$];

    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      send_gap = 0;
    int      send_burst = 0;
    int      recv_gap = 0;
    int      recv_burst = 0;
    tick_t   send_word;
    result_t want;

    always #5 clk = ~clk;

    // Step count after saturation to the eight slots.
    function automatic int live_count();
        return (cfg_count > 4'd8) ? 8 : int'(cfg_count);
    endfunction

    function automatic logic [15:0] action_bit(input int k);
        logic [3:0] id;
        id = cfg_actions[(k & 7) * 4 +: 4];
        return 16'h0001 << id;
    endfunction

    function automatic logic [15:0] slot_timeout(input int k);
        return (k & 4) ? cfg_timeouts_hi[(k & 3) * 16 +: 16]
                       : cfg_timeouts_lo[(k & 3) * 16 +: 16];
    endfunction

    function automatic logic [15:0] sequence_bits();
        logic [15:0] bits;
        int          k;
        bits = '0;
        for (k = 0; k < live_count(); k++)
            bits |= action_bit(k);
        return bits;
    endfunction

    function automatic void rewind_sequence();
        seq_step = 0;
        seq_remaining = slot_timeout(0);
    endfunction

    // Advances the expected sequence state by one tick and returns its result word.
    function automatic result_t detect_tick(input logic [15:0] fired_in,
                                            input logic [15:0] elapsed);
        result_t     r;
        int          cnt;
        logic [15:0] fired;
        logic [15:0] cur_bit;
        logic [15:0] others;
        cnt = live_count();
        fired = fired_in;
        r.trigger_state = TRIG_ONGOING;
        r.event_code = EV_IDLE;
        if (cnt == 0)
        begin
            r.trigger_state = TRIG_NONE;
            r.step_index = 3'(seq_step);
            return r;
        end
        // The first tick after reset drops its mask; a step past the count restarts.
        if (!seq_started)
        begin
            seq_started = 1'b1;
            rewind_sequence();
            fired = '0;
        end
        else if (seq_step >= cnt)
        begin
            rewind_sequence();
        end
        cur_bit = action_bit(seq_step);
        others = fired & ~cur_bit;
        if ((cfg_cancel & others) != 0)
        begin
            rewind_sequence();
            r.trigger_state = TRIG_NONE;
            r.event_code = EV_CANCELLED;
        end
        else if ((sequence_bits() & others) != 0)
        begin
            rewind_sequence();
            r.trigger_state = TRIG_NONE;
            r.event_code = EV_OUT_OF_ORDER;
        end
        else if (seq_step > 0 && elapsed >= seq_remaining)
        begin
            rewind_sequence();
            r.trigger_state = TRIG_NONE;
            r.event_code = EV_TIMEOUT;
        end
        else
        begin
            if (seq_step > 0)
                seq_remaining = seq_remaining - elapsed;
            if ((fired & cur_bit) != 0)
            begin
                if (seq_step + 1 >= cnt)
                begin
                    rewind_sequence();
                    r.trigger_state = TRIG_TRIGGERED;
                    r.event_code = EV_COMPLETED;
                end
                else
                begin
                    seq_step = seq_step + 1;
                    seq_remaining = slot_timeout(seq_step);
                    r.event_code = EV_ADVANCED;
                end
            end
        end
        r.step_index = 3'(seq_step);
        return r;
    endfunction

    // Gap lengths: mostly short, a few long, with occasional stretches of none.
    task automatic pick_gap(inout int burst, output int gap);
        int r;
        gap = 0;
        if (burst > 0)
        begin
            burst--;
        end
        else if ($urandom_range(0, 63) == 0)
        begin
            burst = $urandom_range(20, 100);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
    endtask

    // Tick driver: presents queued words and records the expected result of each accepted one.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            fired_mask <= '0;
            elapsed_ticks <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_results.push_back(detect_tick(fired_mask, elapsed_ticks));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() > 0)
                begin
                    send_word = tick_queue.pop_front();
                    in_valid <= 1'b1;
                    fired_mask <= send_word.fired;
                    elapsed_ticks <= send_word.elapsed;
                    pick_gap(send_burst, send_gap);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with no tick pending: state %0d event %0d step %0d",
                           trigger_state, event_code, step_index);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (trigger_state !== want.trigger_state)
                    begin
                        $error("trigger_state: expected %0d, actual %0d",
                               want.trigger_state, trigger_state);
                        mismatch_count++;
                    end
                    if (event_code !== want.event_code)
                    begin
                        $error("event_code: expected %0d, actual %0d",
                               want.event_code, event_code);
                        mismatch_count++;
                    end
                    if (step_index !== want.step_index)
                    begin
                        $error("step_index: expected %0d, actual %0d",
                               want.step_index, step_index);
                        mismatch_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                pick_gap(recv_burst, recv_gap);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic add_tick(input logic [15:0] fired, input logic [15:0] elapsed);
        tick_t t;
        t.fired = fired;
        t.elapsed = elapsed;
        tick_queue.push_back(t);
    endtask

    task automatic add_noise();
        add_tick(16'($urandom), 16'($urandom));
    endtask

    // Waits until every word has been sent and answered, plus a short settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_STEP_COUNT:    cfg_count = value[3:0];
            REG_STEP_ACTIONS:  cfg_actions = value[31:0];
            REG_TIMEOUTS_LOW:  cfg_timeouts_lo = value;
            REG_TIMEOUTS_HIGH: cfg_timeouts_hi = value;
            REG_CANCEL_MASK:   cfg_cancel = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One pass through the configured sequence, sometimes broken on the way.
    task automatic add_run(inout int added);
        int          cnt;
        int          k;
        int          t;
        int          pick;
        logic [15:0] extra;
        cnt = live_count();
        for (k = 0; k < cnt; k++)
        begin
            t = (k == 0) ? 65535 : int'(slot_timeout(k));
            if ($urandom_range(0, 4) == 0)
            begin
                add_tick(16'h0000, 16'($urandom_range(0, t / 4)));
                added++;
            end
            pick = $urandom_range(0, 29);
            added++;
            if (pick == 0)
            begin
                add_tick(action_bit(k) | (cfg_cancel & 16'($urandom)),
                         16'($urandom_range(0, t / 3)));
                break;
            end
            else if (pick == 1)
            begin
                add_tick(action_bit(int'($urandom_range(0, cnt - 1))),
                         16'($urandom_range(0, t / 3)));
                break;
            end
            else if (pick == 2)
            begin
                add_tick(action_bit(k), 16'($urandom_range(t, 65535)));
                break;
            end
            else
            begin
                extra = '0;
                if ($urandom_range(0, 4) == 0)
                    extra = 16'($urandom) & ~(cfg_cancel | sequence_bits());
                add_tick(action_bit(k) | extra, 16'($urandom_range(0, t / 3)));
            end
        end
    endtask

    function automatic logic [15:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        if (r < 20)
            return 16'hFFFF;
        return 16'($urandom_range(1, 400));
    endfunction

    task automatic random_setup(input int phase);
        logic [3:0]  cnt;
        logic [31:0] acts;
        logic [63:0] lo;
        logic [63:0] hi;
        int          k;
        case (phase)
            0: cnt = 4'd8;
            1: cnt = 4'd15;
            2: cnt = 4'd1;
            4: cnt = 4'd0;
            6: cnt = 4'd12;
            default: cnt = 4'($urandom_range(2, 8));
        endcase
        acts = (phase == 5) ? 32'hFFFF_FFFF : $urandom;
        if (phase == 3)
            acts = 32'h0000_0000;
        for (k = 0; k < 4; k++)
        begin
            lo[k * 16 +: 16] = pick_timeout();
            hi[k * 16 +: 16] = pick_timeout();
        end
        write_reg(REG_STEP_COUNT, 64'(cnt));
        write_reg(REG_STEP_ACTIONS, 64'(acts));
        write_reg(REG_TIMEOUTS_LOW, lo);
        write_reg(REG_TIMEOUTS_HIGH, hi);
        case (phase % 3)
            0: write_reg(REG_CANCEL_MASK, 64'(16'($urandom) & ~sequence_bits()));
            1: write_reg(REG_CANCEL_MASK, 64'hFFFF);
            default: write_reg(REG_CANCEL_MASK, 64'(16'($urandom)));
        endcase
    endtask

    // Stimulus: directed checks first, then randomized phases under varied settings.
    initial
    begin : stimulus
        int phase;
        int added;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty sequence straight after reset.
        add_tick(16'hFFFF, 16'hFFFF);
        add_tick(16'h0000, 16'h0000);
        wait_idle();

        // Three steps on ids 2, 5, 9; id 5 is also a cancel id, id 12 only cancels.
        write_reg(REG_STEP_COUNT, 64'd3);
        write_reg(REG_STEP_ACTIONS, 64'h0000_0952);
        write_reg(REG_TIMEOUTS_LOW, 64'h0000_FFFF_0032_0064);
        write_reg(REG_TIMEOUTS_HIGH, 64'hFFFF_0000_1234_0001);
        write_reg(REG_CANCEL_MASK, 64'h1020);
        add_tick(16'h0004, 16'h0000);   // first tick loses its mask
        add_tick(16'h0004, 16'h0000);   // advance to step one
        add_tick(16'h0020, 16'd10);     // advance to step two
        add_tick(16'h0200, 16'hFFFE);   // just under the longest timeout: completed
        add_tick(16'h0004, 16'h0000);
        add_tick(16'h0000, 16'd50);     // elapsed equal to remaining times out
        add_tick(16'h0004, 16'h0000);
        add_tick(16'h0000, 16'd49);     // one tick left
        add_tick(16'h1000, 16'h0000);   // cancel id
        add_tick(16'h0004, 16'h0000);
        add_tick(16'h0200, 16'h0000);   // later step fired early
        add_tick(16'h0020, 16'h0000);   // cancel wins over out of order
        add_tick(16'h1004, 16'h0000);   // cancel together with the current action
        add_tick(16'h0004, 16'hFFFF);   // no countdown on the first step
        add_tick(16'h0020, 16'h0000);
        wait_idle();

        // Shrink the count while sitting on step two.
        write_reg(REG_STEP_COUNT, 64'd1);
        add_tick(16'h0000, 16'h0000);
        add_tick(16'h0004, 16'h0000);
        wait_idle();

        // Oversized count, every step on the top id, longest timeouts.
        write_reg(REG_STEP_COUNT, 64'd15);
        write_reg(REG_STEP_ACTIONS, 64'hFFFF_FFFF);
        write_reg(REG_TIMEOUTS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_TIMEOUTS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        repeat (8) add_tick(16'h8000, 16'h0001);
        wait_idle();

        // Randomized phases, each ending with the sender held until all results are in.
        for (phase = 0; phase < 8; phase++)
        begin
            random_setup(phase);
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8 && live_count() > 0)
                begin
                    add_run(added);
                end
                else
                begin
                    add_noise();
                    added++;
                end
            end
            wait_idle();
        end

        repeat (5) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
